// ===== src/bounded_levenshtein_distance_assert.svh =====
// Assertion macros used by the top-level RTL of the bounded edit-distance block.
// Each macro checks a property on the rising edge of the given clock and is
// disabled while the given active-low reset is asserted.
`ifndef BOUNDED_LEVENSHTEIN_DISTANCE_ASSERT_SVH
`define BOUNDED_LEVENSHTEIN_DISTANCE_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define BLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bounded_levenshtein_distance: assertion failed");

// The condition must never be true at a clock edge outside reset.
`define BLD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bounded_levenshtein_distance: forbidden condition seen");

`else

`define BLD_ASSERT(lbl, clk, rst_n, prop)
`define BLD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== src/bld_pkg.sv =====
`timescale 1ns / 1ps

package bld_pkg;

    // Number of second-string symbols the chain can hold, one per cell.
    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;
    localparam int VAL_W   = 8;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_ROW    = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    // Token that walks down the chain one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             report;  // finish token: collect the tail value and clear
        logic [SYM_W-1:0] sym;     // first-string symbol of this row
        logic [VAL_W-1:0] diag;    // previous-row value of the cell to the left
        logic [VAL_W-1:0] left;    // new-row value of the cell to the left
    } t_bld_link;

    // Data written into the cell that receives an appended symbol.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [VAL_W-1:0] val;
    } t_bld_load;

    function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W-1:0] v,
                                                  input logic [VAL_W-1:0] cap);
        return (v > cap) ? cap : v;
    endfunction

    function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v,
                                                  input logic [VAL_W-1:0] cap);
        logic [VAL_W:0] sum;
        sum = {1'b0, v} + {{VAL_W{1'b0}}, 1'b1};
        return (sum > {1'b0, cap}) ? cap : sum[VAL_W-1:0];
    endfunction

endpackage

// ===== src/bounded_levenshtein_distance.sv =====
`timescale 1ns / 1ps

// Bounded Levenshtein distance. Load the second string with beats of kind 0
// (one byte each, up to MAX_LEN bytes; extra bytes are dropped and flagged as
// overflow), stream the first string with beats of kind 1, then send one beat
// of kind 2 to get min(distance, max_distance + 1), a within-bound flag and
// the overflow flag; kind 2 also clears the block for the next pair, and kind
// 3 is accepted and ignored. The row of the Wagner-Fischer recurrence lives
// in a chain of MAX_LEN identical cells, one per second-string symbol, and
// each first-string symbol travels down the chain as a token, one cell per
// cycle. Because the tokens are skewed, a kind 1 beat is accepted in every
// cycle. A kind 0 beat waits until the chain has drained of the tokens of
// earlier kind 1 and kind 2 beats. A kind 2 beat sends a report token down
// the whole chain, and m_axis_tvalid rises once it has left the chain;
// only one report is in flight at a time and a kind 2 beat is held back
// while the output register still holds a result.
// Kind 0 and kind 1 beats are taken while a result waits on the output.
// The max_distance register (reset 3, value 255 acts as 254) is written
// through i_cfg_we / i_cfg_wdata and must only be changed while idle. No
// clearing pass is needed after reset.
module bounded_levenshtein_distance
    import bld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // max_distance
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,     // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata      // [7:0] distance, [8] within_bound,
                                          // [9] overflow, [15:10] zero
);

    localparam int CMP_W = (LEN_W + 1 > VAL_W + 1) ? LEN_W + 1 : VAL_W + 1;

    // Configuration and pair state.
    logic [7:0]       r_max;
    logic [VAL_W-1:0] r_cnt0;      // row cell zero: first-string symbols seen
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic [LEN_W-1:0] r_drain;     // cycles until no token is left in the chain
    logic             r_rep_busy;
    logic             r_rep_ovf;
    t_bld_link        r_head;

    // Output register.
    logic             r_out_valid;
    logic [VAL_W-1:0] r_dist;
    logic             r_within;
    logic             r_out_ovf;

    t_kind            w_kind;
    logic             w_fire;
    logic [VAL_W-1:0] w_k;
    logic [VAL_W-1:0] w_cap;
    logic             w_load_fire;
    t_bld_load        w_load;
    logic [CMP_W-1:0] w_len_inc;
    logic [MAX_LEN-1:0] w_load_en;
    t_bld_link        w_link [MAX_LEN+1];
    t_bld_link        w_tail;
    logic [VAL_W-1:0] w_tail_sat;

    assign w_kind = t_kind'(s_axis_tuser);
    assign w_k    = (r_max == 8'd255) ? 8'd254 : r_max;
    assign w_cap  = w_k + 8'd1;

    always_comb begin
        unique case (w_kind)
            KIND_APPEND: s_axis_tready = (r_drain == '0);
            KIND_ROW:    s_axis_tready = 1'b1;
            KIND_FINISH: s_axis_tready = !r_rep_busy && !r_out_valid;
            KIND_NOP:    s_axis_tready = 1'b1;
            default:     s_axis_tready = 1'b1;
        endcase
    end

    assign w_fire = s_axis_tvalid && s_axis_tready;

    // Appending writes the cell at the current length, saturated at the cap.
    assign w_load_fire = w_fire && (w_kind == KIND_APPEND)
                         && (r_len != LEN_W'(MAX_LEN));
    assign w_len_inc   = CMP_W'(r_len) + CMP_W'(1);
    assign w_load.sym  = s_axis_tdata;
    assign w_load.val  = (w_len_inc > CMP_W'(w_cap)) ? w_cap : w_len_inc[VAL_W-1:0];

    assign w_link[0] = r_head;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        assign w_load_en[g] = w_load_fire && (r_len == LEN_W'(g));

        bld_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cap     (w_cap),
            .i_load_en (w_load_en[g]),
            .i_load    (w_load),
            .i_link    (w_link[g]),
            .o_link    (w_link[g+1])
        );
    end

    assign w_tail     = w_link[MAX_LEN];
    assign w_tail_sat = sat_val(w_tail.left, w_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= 8'd3;
            r_cnt0      <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_drain     <= '0;
            r_rep_busy  <= 1'b0;
            r_rep_ovf   <= 1'b0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end

            // A row or finish beat launches a token and restarts the drain count.
            if (w_fire && (w_kind == KIND_ROW || w_kind == KIND_FINISH)) begin
                r_drain <= LEN_W'(MAX_LEN);
            end else begin
                r_head.valid <= 1'b0;
                if (r_drain != '0) begin
                    r_drain <= r_drain - LEN_W'(1);
                end
            end

            if (w_fire) begin
                unique case (w_kind)
                    KIND_APPEND: begin
                        if (r_len == LEN_W'(MAX_LEN)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_len <= r_len + LEN_W'(1);
                        end
                    end
                    KIND_ROW: begin
                        r_cnt0         <= sat_inc(r_cnt0, w_cap);
                        r_head.valid   <= 1'b1;
                        r_head.report  <= 1'b0;
                        r_head.sym     <= s_axis_tdata;
                        r_head.diag    <= r_cnt0;
                        r_head.left    <= sat_inc(r_cnt0, w_cap);
                    end
                    KIND_FINISH: begin
                        r_head.valid   <= 1'b1;
                        r_head.report  <= 1'b1;
                        r_head.sym     <= s_axis_tdata;
                        r_head.diag    <= r_cnt0;
                        r_head.left    <= r_cnt0;
                        r_cnt0         <= '0;
                        r_len          <= '0;
                        r_ovf          <= 1'b0;
                        r_rep_busy     <= 1'b1;
                        r_rep_ovf      <= r_ovf;
                    end
                    KIND_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end

            // The report token leaves the chain carrying the last row value.
            if (w_tail.valid && w_tail.report) begin
                r_out_valid <= 1'b1;
                r_dist      <= w_tail_sat;
                r_within    <= (w_tail_sat <= w_k);
                r_out_ovf   <= r_rep_ovf;
                r_rep_busy  <= 1'b0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_ovf, r_within, r_dist};

`include "bounded_levenshtein_distance_assert.svh"

    `BLD_NEVER(a_len_range, i_clk, i_rst_n, r_len > LEN_W'(MAX_LEN))
    `BLD_NEVER(a_result_not_lost, i_clk, i_rst_n, w_tail.valid && w_tail.report && r_out_valid)
    `BLD_ASSERT(a_report_tracked, i_clk, i_rst_n, (w_tail.valid && w_tail.report) |-> r_rep_busy)
    `BLD_ASSERT(a_finish_clears, i_clk, i_rst_n, (w_fire && w_kind == KIND_FINISH) |=> (r_len == '0 && r_cnt0 == '0 && !r_ovf))

endmodule

// ===== src/bld_cell.sv =====
`timescale 1ns / 1ps

// One column of the edit-distance row: holds one second-string symbol and
// its row value; a row token updates the value, a report token clears it.
module bld_cell
    import bld_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VAL_W-1:0] i_cap,
    input  logic             i_load_en,
    input  t_bld_load        i_load,
    input  t_bld_link        i_link,
    output t_bld_link        o_link
);

    logic             r_act;
    logic [VAL_W-1:0] r_val;
    logic [SYM_W-1:0] r_sym;
    t_bld_link        r_link;

    logic [VAL_W-1:0] w_min;
    logic [VAL_W-1:0] w_new;
    t_bld_link        n_link;

    always_comb begin
        w_min = r_val;
        if (i_link.left < w_min) begin
            w_min = i_link.left;
        end
        if (i_link.diag < w_min) begin
            w_min = i_link.diag;
        end
        if (i_link.sym == r_sym) begin
            w_new = sat_val(i_link.diag, i_cap);
        end else begin
            w_new = sat_inc(w_min, i_cap);
        end
    end

    always_comb begin
        n_link.valid  = i_link.valid;
        n_link.report = i_link.report;
        n_link.sym    = i_link.sym;
        n_link.diag   = r_val;
        if (!r_act) begin
            n_link.left = i_link.left;
        end else if (i_link.report) begin
            n_link.left = r_val;
        end else begin
            n_link.left = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_val  <= '0;
            r_link <= '0;
        end else begin
            r_link <= n_link;
            if (i_load_en) begin
                r_act <= 1'b1;
                r_val <= i_load.val;
            end else if (i_link.valid && i_link.report) begin
                r_act <= 1'b0;
                r_val <= '0;
            end else if (i_link.valid && r_act) begin
                r_val <= w_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_sym <= i_load.sym;
        end
    end

    assign o_link = r_link;

endmodule

// ===== tb/sv/tb_bld_checker.sv =====
`timescale 1ns / 1ps

// Follows both streams of the bounded edit-distance block, keeps its own copy
// of the DP row and the stored string, and compares every distance beat with
// the oldest distance still owed.
module tb_bld_checker
    import bld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    // Same bit order as m_axis_tdata[9:0].
    typedef struct packed {
        logic             overflow;
        logic             within_bound;
        logic [VAL_W-1:0] distance;
    } t_distance_result;

    logic [VAL_W-1:0]  row_val [0:MAX_LEN];
    logic [SYM_W-1:0]  second_sym [0:MAX_LEN-1];
    int                second_len;
    logic              overflow_seen;
    logic [7:0]        max_distance;
    t_distance_result  owed_distances [$];
    int                reports;

    // A register value of 255 behaves as 254.
    function automatic int bound_k();
        return (max_distance > 8'd254) ? 254 : int'(max_distance);
    endfunction

    function automatic int clip(input int v, input int cap);
        return (v > cap) ? cap : v;
    endfunction

    task automatic clear_pair();
        for (int j = 0; j <= MAX_LEN; j++) begin
            row_val[j] = '0;
        end
        second_len    = 0;
        overflow_seen = 1'b0;
    endtask

    task automatic advance_edit_row(input t_kind kind, input logic [SYM_W-1:0] sym);
        int               cap;
        int               diag;
        int               above;
        int               best;
        t_distance_result res;
        cap = bound_k() + 1;
        case (kind)
            KIND_APPEND: begin
                if (second_len >= MAX_LEN) begin
                    overflow_seen = 1'b1;
                end else begin
                    second_sym[second_len] = sym;
                    second_len++;
                    row_val[second_len] = VAL_W'(clip(second_len, cap));
                end
            end
            KIND_ROW: begin
                diag = int'(row_val[0]);
                row_val[0] = VAL_W'(clip(diag + 1, cap));
                for (int j = 1; j <= second_len; j++) begin
                    above = int'(row_val[j]);
                    if (sym != second_sym[j-1]) begin
                        best = above;
                        if (int'(row_val[j-1]) < best) best = int'(row_val[j-1]);
                        if (diag < best) best = diag;
                        row_val[j] = VAL_W'(clip(best + 1, cap));
                    end else begin
                        row_val[j] = VAL_W'(clip(diag, cap));
                    end
                    diag = above;
                end
            end
            KIND_FINISH: begin
                res.distance     = VAL_W'(clip(int'(row_val[second_len]), cap));
                res.within_bound = (int'(res.distance) <= bound_k());
                res.overflow     = overflow_seen;
                owed_distances.push_back(res);
                clear_pair();
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        reports      = 0;
        max_distance = 8'd3;
        clear_pair();
    end

    always @(posedge i_clk) begin : watch
        t_distance_result seen;
        t_distance_result want;
        if (!i_rst_n) begin
            max_distance = 8'd3;
            clear_pair();
            owed_distances.delete();
        end else begin
            if (i_cfg_we) begin
                max_distance = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_edit_row(t_kind'(i_s_tuser), i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                seen = t_distance_result'(i_m_tdata[9:0]);
                if (owed_distances.size() == 0) begin
                    o_fail_count++;
                    if (reports < 10) begin
                        $display("unexpected result beat: dist %0d within %0b overflow %0b",
                                 seen.distance, seen.within_bound, seen.overflow);
                    end
                    reports++;
                end else begin
                    want = owed_distances.pop_front();
                    if (seen.distance !== want.distance ||
                        seen.within_bound !== want.within_bound ||
                        seen.overflow !== want.overflow) begin
                        o_fail_count++;
                        if (reports < 10) begin
                            $display({"result mismatch: expected dist %0d within %0b ",
                                      "overflow %0b, got dist %0d within %0b overflow %0b"},
                                     want.distance, want.within_bound, want.overflow,
                                     seen.distance, seen.within_bound, seen.overflow);
                        end
                        reports++;
                    end
                end
            end
        end
        o_pending = owed_distances.size();
    end

endmodule

// ===== tb/sv/tb_bounded_levenshtein_distance.sv =====
`timescale 1ns / 1ps

// Top of the bench for the bounded edit-distance block. This module only
// makes stimulus and gives the verdict; the checker beside the block follows
// both streams, predicts each distance beat and counts failures.
module tb_bounded_levenshtein_distance
    import bld_pkg::*;
();

    // The chain holds MAX_LEN cells; every quiet period waits longer than a
    // finish token or a chain drain needs to pass through them.
    localparam int DRAIN_CYCLES = MAX_LEN + 8;
    localparam int TARGET_ITEMS = 800;
    // Bounds the slowest legal run (appends that wait for a drain, long sender
    // gaps, heavy output stalls) with a wide margin.
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    int fail_count;
    int pending_count;

    // Sender state: beats go out in bursts; steady_sender turns the gaps off
    // for a whole pair so that back-to-back stretches also occur.
    int burst_left;
    bit steady_sender;
    int items_sent;

    // Receiver state: tready follows an 8-bit pattern that is swapped for a
    // new one whenever rx_phase is a multiple of 256.
    logic [7:0] stall_pattern;
    int         rx_phase;

    bounded_levenshtein_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tb_bld_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either stream.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Output stalls. The patterns range from always ready to one ready cycle
    // in eight, so the result register is often held across stalls.
    always @(negedge i_clk) begin
        if (rx_phase % 256 == 0) begin
            case ($urandom_range(0, 4))
                0:       stall_pattern = 8'hFF;
                1:       stall_pattern = 8'h01;
                2:       stall_pattern = 8'hAA;
                3:       stall_pattern = 8'hF0;
                default: stall_pattern = $urandom_range(1, 255);
            endcase
        end
        m_axis_tready <= stall_pattern[rx_phase % 8];
        rx_phase++;
    end

    // The small alphabet gives frequent matches along the row; the wide one
    // toggles every bit of the symbol.
    function automatic logic [7:0] next_symbol(input bit wide);
        return wide ? 8'($urandom_range(0, 255)) : 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] pick_max_distance();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd3;
            4:       return 8'd254;
            5:       return 8'd255;
            6:       return 8'($urandom_range(4, 16));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called right after a falling edge. Holds tvalid until the beat is taken
    // and returns at the following falling edge without driving anything
    // there, so the next call may drive the bus in the same time step.
    task automatic send_beat(input t_kind kind, input logic [7:0] sym);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_sender ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (kind != KIND_NOP) items_sent++;
        @(negedge i_clk);
    endtask

    // Brings the block to rest: no distance still owed, and the chain has had
    // time to drain any row or finish tokens that produce nothing.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Only called with the block at rest.
    task automatic write_max_distance(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        // Both strings empty, with the reset bound of 3: distance 0.
        send_beat(KIND_FINISH, 8'h00);

        // Only the first string: five symbols against nothing, capped at 4.
        for (int i = 0; i < 5; i++) begin
            send_beat(KIND_ROW, 8'h61 + 8'(i));
        end
        send_beat(KIND_FINISH, 8'hFF);

        // Equal strings with an ignored kind 3 beat in the middle.
        send_beat(KIND_APPEND, 8'h61);
        send_beat(KIND_APPEND, 8'h62);
        send_beat(KIND_NOP, 8'h5A);
        send_beat(KIND_ROW, 8'h61);
        send_beat(KIND_ROW, 8'h62);
        send_beat(KIND_FINISH, 8'h00);

        // Bound 0: a single substitution is already out of bound.
        settle_block();
        write_max_distance(8'd0);
        send_beat(KIND_APPEND, 8'h00);
        send_beat(KIND_ROW, 8'hFF);
        send_beat(KIND_FINISH, 8'h00);

        // Largest bound, extreme symbols, and an append that arrives after a
        // row has already been processed.
        settle_block();
        write_max_distance(8'd254);
        send_beat(KIND_APPEND, 8'hFF);
        send_beat(KIND_APPEND, 8'h00);
        send_beat(KIND_ROW, 8'h00);
        send_beat(KIND_APPEND, 8'h5A);
        send_beat(KIND_ROW, 8'hFF);
        send_beat(KIND_FINISH, 8'h00);

        // The bound drops in the middle of a pair while the block is at rest;
        // later updates and the report use the new value.
        send_beat(KIND_APPEND, 8'h78);
        send_beat(KIND_ROW, 8'h79);
        send_beat(KIND_ROW, 8'h7A);
        settle_block();
        write_max_distance(8'd1);
        send_beat(KIND_ROW, 8'h78);
        send_beat(KIND_FINISH, 8'h00);

        // 255 is out of range and must act as 254.
        settle_block();
        write_max_distance(8'd255);
    endtask

    // One string pair: load the second string, stream a first string that is
    // either an edited copy of it or unrelated, then ask for the distance.
    // A few pairs carry noise beats, a late append, a mid-pair bound change
    // or a broken tail with random kinds.
    task automatic run_pair(input bit force_full);
        logic [7:0] second_q [$];
        logic [7:0] first_q [$];
        int         n;
        int         m;
        int         edits;
        int         pos;
        int         late_at;
        int         retune_at;
        bit         wide;
        logic [7:0] sym;

        wide          = ($urandom_range(0, 3) == 0);
        steady_sender = ($urandom_range(0, 3) == 0);

        // Mostly short strings; sometimes a full store or more than it holds.
        case ($urandom_range(0, 29))
            0:               n = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
            1, 2:            n = $urandom_range(31, MAX_LEN);
            3, 4, 5, 6, 7:   n = $urandom_range(9, 30);
            default:         n = $urandom_range(0, 8);
        endcase
        if (force_full) n = MAX_LEN + 2;

        for (int i = 0; i < n; i++) begin
            sym = next_symbol(wide);
            second_q.push_back(sym);
            if ($urandom_range(0, 24) == 0) send_beat(KIND_NOP, 8'($urandom_range(0, 255)));
            send_beat(KIND_APPEND, sym);
        end

        if ($urandom_range(0, 1) == 1) begin
            first_q = second_q;
            edits = $urandom_range(0, 4);
            for (int e = 0; e < edits; e++) begin
                sym = next_symbol(wide);
                case ($urandom_range(0, 2))
                    0: begin
                        if (first_q.size() > 0) begin
                            pos = $urandom_range(0, first_q.size() - 1);
                            first_q[pos] = sym;
                        end
                    end
                    1: begin
                        pos = $urandom_range(0, first_q.size());
                        first_q.insert(pos, sym);
                    end
                    default: begin
                        if (first_q.size() > 0) begin
                            pos = $urandom_range(0, first_q.size() - 1);
                            first_q.delete(pos);
                        end
                    end
                endcase
            end
        end else begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            for (int i = 0; i < m; i++) begin
                first_q.push_back(next_symbol(wide));
            end
        end

        late_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, first_q.size()) : -1;
        retune_at = ($urandom_range(0, 29) == 0) ? first_q.size() / 2 : -1;
        for (int i = 0; i < first_q.size(); i++) begin
            if (i == late_at) send_beat(KIND_APPEND, next_symbol(wide));
            if (i == retune_at) begin
                settle_block();
                write_max_distance(pick_max_distance());
            end
            if ($urandom_range(0, 24) == 0) send_beat(KIND_NOP, 8'($urandom_range(0, 255)));
            send_beat(KIND_ROW, first_q[i]);
        end

        // Broken tail: a few beats of random kind, any of which may finish early.
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                send_beat(t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        send_beat(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = KIND_NOP;
        m_axis_tready = 1'b0;
        stall_pattern = 8'hFF;
        rx_phase      = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        items_sent    = 0;

        // Reset is held low from the start and released at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // The first random pair overfills the store so that truncation is
        // always covered.
        run_pair(1'b1);
        while (items_sent < TARGET_ITEMS) begin
            run_pair(1'b0);
            if ($urandom_range(0, 5) == 0) begin
                settle_block();
                write_max_distance(pick_max_distance());
            end
        end

        settle_block();
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
